// ----- rtl/core/gpfd_pkg.sv -----
`default_nettype none

package gpfd_pkg;

	// Frame layout.
	localparam int DATA_BYTES = 6;
	localparam int POS_W = 4;
	localparam int BYTE_W = 8;
	localparam int BTN_W = 16;
	localparam int DZ_W = 7;

	// Only the data bytes ahead of the last one are held; the last one is used directly.
	localparam int FB_DEPTH = DATA_BYTES - 1;
	localparam int FB_IDX_W = $clog2(FB_DEPTH);

	localparam logic [POS_W-1:0] POS_MODE = POS_W'(1);
	localparam logic [POS_W-1:0] POS_ACK = POS_W'(2);
	localparam logic [POS_W-1:0] FIRST_DATA_POS = POS_W'(3);
	localparam logic [POS_W-1:0] LAST_DATA_POS = POS_W'(3 + DATA_BYTES - 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(15);

	localparam logic [BYTE_W-1:0] ACK_BYTE = 8'h5A;
	localparam logic [BYTE_W-1:0] RED_MODE_ID = 8'h73;
	localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 7'd3;

	// Result status codes.
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_BAD_ACK = 1'b1;

	// One decoded result.
	typedef struct packed {
		logic status;
		logic [BTN_W-1:0] buttons;
		logic signed [BYTE_W-1:0] right_x;
		logic signed [BYTE_W-1:0] right_y;
		logic signed [BYTE_W-1:0] left_x;
		logic signed [BYTE_W-1:0] left_y;
		logic red_mode;
	} result_t;

	// What the frame core hands to the output stage.
	typedef struct packed {
		logic valid;
		result_t data;
	} core_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/gpfd_if.sv -----
`default_nettype none

// Received byte channel.
interface gpfd_in_if;
	logic valid;
	logic ready;
	logic [gpfd_pkg::BYTE_W-1:0] rx_byte;
	logic frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Decoded frame channel.
interface gpfd_out_if;
	logic valid;
	logic ready;
	logic status;
	logic [gpfd_pkg::BTN_W-1:0] buttons;
	logic signed [gpfd_pkg::BYTE_W-1:0] right_x;
	logic signed [gpfd_pkg::BYTE_W-1:0] right_y;
	logic signed [gpfd_pkg::BYTE_W-1:0] left_x;
	logic signed [gpfd_pkg::BYTE_W-1:0] left_y;
	logic red_mode;

	modport source (output valid, output status, output buttons, output right_x,
		output right_y, output left_x, output left_y, output red_mode, input ready);
	modport sink (input valid, input status, input buttons, input right_x,
		input right_y, input left_x, input left_y, input red_mode, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gpfd_stick.sv -----
`default_nettype none

module gpfd_stick (
	input  logic [gpfd_pkg::BYTE_W-1:0] raw,
	input  logic y_axis,
	input  logic [gpfd_pkg::DZ_W-1:0] dead_zone,
	output logic signed [gpfd_pkg::BYTE_W-1:0] value
);

	logic [gpfd_pkg::BYTE_W-1:0] centered;
	logic [gpfd_pkg::BYTE_W-1:0] mag;

	// X is raw minus 128; Y is 127 minus raw, which is the X value bitwise inverted.
	assign centered = y_axis ? {raw[7], ~raw[6:0]} : {~raw[7], raw[6:0]};

	// Magnitude fits in eight unsigned bits, including 128 for the most negative value.
	assign mag = centered[7] ? (~centered + 8'd1) : centered;

	// Small deflections are reported as rest.
	assign value = (mag < {1'b0, dead_zone}) ? '0 : $signed(centered);

endmodule

`default_nettype wire

// ----- rtl/core/gpfd_core.sv -----
`default_nettype none

module gpfd_core (
	input  logic clk,
	input  logic arst_n,
	gpfd_in_if.sink in_ch,
	input  logic [gpfd_pkg::DZ_W-1:0] dead_zone,
	input  logic load_ok,
	output gpfd_pkg::core_res_t res
);

	// Input register.
	logic valid_s1;
	logic [gpfd_pkg::BYTE_W-1:0] rx_byte_s1;
	logic frame_start_s1;

	// Frame state.
	logic [gpfd_pkg::POS_W-1:0] byte_position_q;
	logic frame_dropped_q;
	logic [gpfd_pkg::BYTE_W-1:0] mode_id_q;
	logic [gpfd_pkg::BYTE_W-1:0] frame_bytes_q [gpfd_pkg::FB_DEPTH];
	logic [gpfd_pkg::BTN_W-1:0] previous_buttons_q;
	logic [gpfd_pkg::BTN_W-1:0] agreed_buttons_q;

	logic accept;
	logic advance;
	logic fire;
	logic [gpfd_pkg::POS_W-1:0] pos;
	logic [gpfd_pkg::POS_W-1:0] pos_next;
	logic dropped_eff;
	logic is_mode;
	logic ack_bad;
	logic in_data;
	logic is_last;
	logic [gpfd_pkg::FB_IDX_W-1:0] fb_idx;
	logic [gpfd_pkg::BTN_W-1:0] cur_buttons;
	logic [gpfd_pkg::BTN_W-1:0] agreed_next;
	logic signed [gpfd_pkg::BYTE_W-1:0] rx_val;
	logic signed [gpfd_pkg::BYTE_W-1:0] ry_val;
	logic signed [gpfd_pkg::BYTE_W-1:0] lx_val;
	logic signed [gpfd_pkg::BYTE_W-1:0] ly_val;

	// The held byte moves on unless its result cannot be loaded yet.
	assign advance = !res.valid || load_ok;
	assign fire = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;
	assign accept = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_byte_s1 <= in_ch.rx_byte;
			frame_start_s1 <= in_ch.frame_start;
		end
	end

	// Byte position and the classification of the held byte.
	assign pos = frame_start_s1 ? '0 : byte_position_q;
	assign pos_next = (pos == gpfd_pkg::POS_MAX) ? pos : pos + 1'b1;
	assign dropped_eff = frame_start_s1 ? 1'b0 : frame_dropped_q;
	assign is_mode = (pos == gpfd_pkg::POS_MODE);
	assign ack_bad = (pos == gpfd_pkg::POS_ACK) && (rx_byte_s1 != gpfd_pkg::ACK_BYTE);
	assign in_data = !dropped_eff && (pos >= gpfd_pkg::FIRST_DATA_POS)
		&& (pos <= gpfd_pkg::LAST_DATA_POS);
	assign is_last = in_data && (pos == gpfd_pkg::LAST_DATA_POS);
	assign fb_idx = gpfd_pkg::FB_IDX_W'(pos - gpfd_pkg::FIRST_DATA_POS);

	// Buttons are active low on the wire; the first button byte is the low half.
	assign cur_buttons = ~{frame_bytes_q[1], frame_bytes_q[0]};
	assign agreed_next = (cur_buttons == previous_buttons_q) ? cur_buttons : agreed_buttons_q;

	// Stick conversion; the left Y byte is the one arriving now.
	gpfd_stick u_right_x (.raw(frame_bytes_q[2]), .y_axis(1'b0), .dead_zone(dead_zone),
		.value(rx_val));
	gpfd_stick u_right_y (.raw(frame_bytes_q[3]), .y_axis(1'b1), .dead_zone(dead_zone),
		.value(ry_val));
	gpfd_stick u_left_x (.raw(frame_bytes_q[4]), .y_axis(1'b0), .dead_zone(dead_zone),
		.value(lx_val));
	gpfd_stick u_left_y (.raw(rx_byte_s1), .y_axis(1'b1), .dead_zone(dead_zone),
		.value(ly_val));

	// Result toward the output register.
	always_comb begin
		res.valid = valid_s1 && (ack_bad || is_last);
		res.data.red_mode = (mode_id_q == gpfd_pkg::RED_MODE_ID);
		if (ack_bad) begin
			res.data.status = gpfd_pkg::STATUS_BAD_ACK;
			res.data.buttons = agreed_buttons_q;
			res.data.right_x = '0;
			res.data.right_y = '0;
			res.data.left_x = '0;
			res.data.left_y = '0;
		end else begin
			res.data.status = gpfd_pkg::STATUS_OK;
			res.data.buttons = agreed_next;
			res.data.right_x = rx_val;
			res.data.right_y = ry_val;
			res.data.left_x = lx_val;
			res.data.left_y = ly_val;
		end
	end

	// Frame state update when the held byte moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			frame_dropped_q <= 1'b0;
			mode_id_q <= '0;
			previous_buttons_q <= '0;
			agreed_buttons_q <= '0;
		end else if (fire) begin
			byte_position_q <= pos_next;
			frame_dropped_q <= ack_bad ? 1'b1 : dropped_eff;
			if (is_mode) begin
				mode_id_q <= rx_byte_s1;
			end
			if (is_last) begin
				previous_buttons_q <= cur_buttons;
				agreed_buttons_q <= agreed_next;
			end
		end
	end

	// Data bytes ahead of the last one.
	always_ff @(posedge clk) begin
		if (fire && in_data && !is_last) begin
			frame_bytes_q[fb_idx] <= rx_byte_s1;
		end
	end

	// A result comes only from an acknowledge byte or the last data byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (pos == gpfd_pkg::POS_ACK || pos == gpfd_pkg::LAST_DATA_POS))
		else $error("result raised at a position that cannot produce one");

	// A new frame always clears the dropped flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && frame_start_s1) |=> !frame_dropped_q)
		else $error("frame start did not clear the dropped flag");

	// After any byte is consumed the next position is never the frame's first byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (byte_position_q != '0))
		else $error("position count wrapped to zero");

	// A held byte whose result is blocked stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(rx_byte_s1)
			&& $stable(byte_position_q)))
		else $error("stalled byte or frame state changed");

endmodule

`default_nettype wire

// ----- rtl/core/gamepad_poll_frame_decoder.sv -----
// Gamepad poll frame decoder.
// in_ch carries the bytes of one controller poll, one byte per transfer; frame_start
// marks the first byte of a frame. Byte 1 is the mode ID, byte 2 the acknowledge
// byte, and six data bytes follow: two button bytes, then right X, right Y, left X,
// left Y. out_ch carries one transfer per frame on its last data byte, or one error
// transfer (status set, sticks zero) on a bad acknowledge byte.
// cfg_wr_en / cfg_wr_data write the stick dead zone; write it only while idle.
// A byte accepted from in_ch sits in the input register; its result is then loaded
// into the output register, from which out_ch takes it. One byte is accepted every
// cycle while no byte that makes a result waits in the input register.
// The output register decouples the two sides: while a result waits, bytes that
// make no result keep flowing, and a byte that makes a result waits in the input
// register until the output register frees, which then back-pressures in_ch.
// Reset clears the position count, mode ID, button history and dead zone (to 3);
// the first byte after reset counts as byte 0 of a frame.
`default_nettype none

module gamepad_poll_frame_decoder (
	input  logic clk,
	input  logic arst_n,
	gpfd_in_if.sink in_ch,
	gpfd_out_if.source out_ch,
	input  logic cfg_wr_en,
	input  logic [gpfd_pkg::DZ_W-1:0] cfg_wr_data
);

	logic [gpfd_pkg::DZ_W-1:0] dead_zone_q;
	logic out_valid_q;
	gpfd_pkg::result_t out_q;
	gpfd_pkg::core_res_t res;
	logic load_ok;

	// Dead zone register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= gpfd_pkg::DEAD_ZONE_RESET;
		end else if (cfg_wr_en) begin
			dead_zone_q <= cfg_wr_data;
		end
	end

	gpfd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.dead_zone(dead_zone_q),
		.load_ok(load_ok),
		.res(res)
	);

	// Output register.
	assign load_ok = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_ok) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && res.valid) begin
			out_q <= res.data;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = out_q.status;
	assign out_ch.buttons = out_q.buttons;
	assign out_ch.right_x = out_q.right_x;
	assign out_ch.right_y = out_q.right_y;
	assign out_ch.left_x = out_q.left_x;
	assign out_ch.left_y = out_q.left_y;
	assign out_ch.red_mode = out_q.red_mode;

	// An error result never carries stick values.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == gpfd_pkg::STATUS_BAD_ACK)
			|-> (out_q.right_x == '0 && out_q.right_y == '0
				&& out_q.left_x == '0 && out_q.left_y == '0))
		else $error("error result carries stick values");

endmodule

`default_nettype wire
